>>> rtl/fpl_pkg.sv
// ----------------------------------------------------------------------------
// Five-point Laplacian stencil: shared package
// Register indexes, field widths and the result tag that travels between the
// stencil window and the scaling pipeline.
// ----------------------------------------------------------------------------
package fpl_pkg;

    localparam int GRID_SIZE_W = 9;
    localparam int SCALE_W     = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int COORD_W     = 8;
    localparam int FRAC_W      = 16;
    localparam int GRID_RESET  = 16;

    localparam logic [SCALE_W-1:0]   SCALE_RESET        = 32'h0001_0000;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMBINED_SCALE = 2'd1;

    typedef struct packed {
        logic               done;
        logic               last;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } t_res_meta;

endpackage

>>> rtl/fpl_line_store.sv
// ----------------------------------------------------------------------------
// Line store
// One row of samples: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fpl_line_store #(
    parameter  int DEPTH = 256,
    parameter  int WIDTH = 32,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/fpl_window.sv
// ----------------------------------------------------------------------------
// Stencil window
// Raster counters, line stores and neighbour registers; forms the stencil
// sums of up to three points per sample, issued one per cycle unless stalled.
// ----------------------------------------------------------------------------
module fpl_window
    import fpl_pkg::*;
#(
    parameter  int GRID_MAX   = 256,
    parameter  int DATA_WIDTH = 32,
    localparam int CNT_W      = $clog2(GRID_MAX),
    localparam int N_W        = $clog2(GRID_MAX + 1),
    localparam int ACC_W      = DATA_WIDTH + 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [N_W-1:0]               i_grid_n,
    input  logic                         i_restart,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [DATA_WIDTH-1:0] i_sample,
    input  logic signed [DATA_WIDTH-1:0] i_boundary,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [ACC_W-1:0]      o_acc,
    output t_res_meta                    o_meta
);

    localparam int PEND_A = 0;
    localparam int PEND_B = 1;
    localparam int PEND_C = 2;

    logic [CNT_W-1:0] r_col, r_row, n_col, n_row;
    logic [CNT_W-1:0] w_c, w_r;
    logic             w_wrap;
    logic             w_has_a, w_up_ok, w_left_ok, w_left2_ok, w_right_ok;
    logic             w_last_row, w_last_col;
    logic             w_accept, w_send, w_last;
    logic [2:0]       r_pend, n_pend, w_new_pend, w_sel, w_rest;
    logic             r_up_we;

    logic signed [DATA_WIDTH-1:0] w_old_c, w_old_b, w_right, w_upper;
    logic signed [DATA_WIDTH-1:0] r_s1_x, r_s1_b;
    logic signed [DATA_WIDTH-1:0] r_left0, r_left1, r_left2, r_leftb;
    logic [CNT_W-1:0]             r_s1_c, r_s1_r;
    logic                         r_s1_up_ok, r_s1_left_ok, r_s1_left2_ok, r_s1_right_ok;
    logic                         r_s1_last_row, r_s1_last_col;

    logic signed [ACC_W-1:0] w_acc_a, w_acc_b, w_acc_c;
    logic [COORD_W-1:0]      w_c8, w_r8;

    // raster position of the incoming sample
    assign w_wrap = (N_W'(r_col) >= i_grid_n) || (N_W'(r_row) >= i_grid_n);
    assign w_c    = w_wrap ? '0 : r_col;
    assign w_r    = w_wrap ? '0 : r_row;

    assign w_has_a    = (w_r != '0);
    assign w_up_ok    = (w_r > CNT_W'(1));
    assign w_left_ok  = (w_c != '0);
    assign w_left2_ok = (w_c > CNT_W'(1));
    assign w_right_ok = ((N_W'(w_c) + N_W'(1)) < i_grid_n);
    assign w_last_row = (N_W'(w_r) == (i_grid_n - N_W'(1)));
    assign w_last_col = (N_W'(w_c) == (i_grid_n - N_W'(1)));

    assign w_new_pend = {w_last_row && w_last_col, w_last_row && w_left_ok, w_has_a};

    // issue order: point above, then left point of the last row, then the final point
    assign w_sel  = r_pend & (~r_pend + 3'd1);
    assign w_rest = r_pend & ~w_sel;
    assign w_last = (w_rest == '0);

    assign o_valid  = (r_pend != '0);
    assign w_send   = o_valid && i_ready;
    assign o_ready  = (r_pend == '0) || (w_send && w_last);
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_restart) begin
            n_col = '0;
            n_row = '0;
        end else if (w_accept) begin
            n_col = w_last_col ? '0 : w_c + CNT_W'(1);
            n_row = !w_last_col ? w_r : (w_last_row ? '0 : w_r + CNT_W'(1));
        end
    end

    always_comb begin
        n_pend = r_pend;
        if (w_accept) begin
            n_pend = w_new_pend;
        end else if (w_send) begin
            n_pend = w_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_pend  <= '0;
            r_up_we <= 1'b0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_pend  <= n_pend;
            r_up_we <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_left0       <= w_old_c;
            r_left1       <= r_s1_x;
            r_left2       <= r_left1;
            r_leftb       <= r_s1_b;
            r_s1_x        <= i_sample;
            r_s1_b        <= i_boundary;
            r_s1_c        <= w_c;
            r_s1_r        <= w_r;
            r_s1_up_ok    <= w_up_ok;
            r_s1_left_ok  <= w_left_ok;
            r_s1_left2_ok <= w_left2_ok;
            r_s1_right_ok <= w_right_ok;
            r_s1_last_row <= w_last_row;
            r_s1_last_col <= w_last_col;
        end
    end

    fpl_line_store #(.DEPTH(GRID_MAX), .WIDTH(DATA_WIDTH)) u_centre (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (w_c),
        .i_wdata (i_sample),
        .i_re    (w_accept),
        .i_raddr (w_c),
        .o_rdata (w_old_c)
    );

    fpl_line_store #(.DEPTH(GRID_MAX), .WIDTH(DATA_WIDTH)) u_centre_nx (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (w_c),
        .i_wdata (i_sample),
        .i_re    (w_accept),
        .i_raddr (w_c + CNT_W'(1)),
        .o_rdata (w_right)
    );

    fpl_line_store #(.DEPTH(GRID_MAX), .WIDTH(DATA_WIDTH)) u_bound (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (w_c),
        .i_wdata (i_boundary),
        .i_re    (w_accept),
        .i_raddr (w_c),
        .o_rdata (w_old_b)
    );

    // demote the old centre sample to the upper row in the cycle after accept
    fpl_line_store #(.DEPTH(GRID_MAX), .WIDTH(DATA_WIDTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (r_up_we),
        .i_waddr (r_s1_c),
        .i_wdata (w_old_c),
        .i_re    (w_accept),
        .i_raddr (w_c),
        .o_rdata (w_upper)
    );

    assign w_acc_a = ACC_W'(w_old_b) + ACC_W'(r_s1_x)
                   + (r_s1_left_ok  ? ACC_W'(r_left0) : '0)
                   + (r_s1_right_ok ? ACC_W'(w_right) : '0)
                   + (r_s1_up_ok    ? ACC_W'(w_upper) : '0)
                   - (ACC_W'(w_old_c) <<< 2);

    assign w_acc_b = ACC_W'(r_leftb) + ACC_W'(r_s1_x) + ACC_W'(r_left0)
                   + (r_s1_left2_ok ? ACC_W'(r_left2) : '0)
                   - (ACC_W'(r_left1) <<< 2);

    assign w_acc_c = ACC_W'(r_s1_b) + ACC_W'(r_left1) + ACC_W'(w_old_c)
                   - (ACC_W'(r_s1_x) <<< 2);

    assign w_c8 = COORD_W'(r_s1_c);
    assign w_r8 = COORD_W'(r_s1_r);

    always_comb begin
        o_acc       = w_acc_c;
        o_meta.col  = w_c8;
        o_meta.row  = w_r8;
        o_meta.last = w_last;
        o_meta.done = w_sel[PEND_C];
        if (w_sel[PEND_A]) begin
            o_acc      = w_acc_a;
            o_meta.row = w_r8 - COORD_W'(1);
        end else if (w_sel[PEND_B]) begin
            o_acc      = w_acc_b;
            o_meta.col = w_c8 - COORD_W'(1);
        end
    end

    a_counters_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (N_W'(r_col) < i_grid_n) && (N_W'(r_row) < i_grid_n))
        else $error("raster counter outside grid");

    a_final_point_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_meta.done) |-> (r_s1_last_row && r_s1_last_col))
        else $error("final point issued away from grid corner");

    a_upper_write_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_up_we |-> $past(w_accept))
        else $error("upper row write without request");

endmodule

>>> rtl/fpl_scale.sv
// ----------------------------------------------------------------------------
// Scaling pipeline
// Magnitude, split Q16.16 multiply, round half away from zero, saturate,
// and the result register.
// ----------------------------------------------------------------------------
module fpl_scale
    import fpl_pkg::*;
#(
    parameter  int DATA_WIDTH = 32,
    localparam int ACC_W      = DATA_WIDTH + 4,
    localparam int MAG_W      = DATA_WIDTH + 3,
    localparam int PP_W       = MAG_W + FRAC_W,
    localparam int SUM_W      = MAG_W + SCALE_W + 1,
    localparam int RND_W      = SUM_W - FRAC_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [SCALE_W-1:0]    i_scale,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [ACC_W-1:0] i_acc,
    input  t_res_meta             i_meta,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [DATA_WIDTH-1:0] o_value,
    output logic                  o_overflow,
    output t_res_meta             o_meta
);

    localparam logic [RND_W-1:0]      LIM_NEG = RND_W'({1'b1, {(DATA_WIDTH-1){1'b0}}});
    localparam logic [RND_W-1:0]      LIM_POS = LIM_NEG - RND_W'(1);
    localparam logic [DATA_WIDTH-1:0] VAL_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] VAL_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [SUM_W-1:0]      HALF    = SUM_W'(1) << (FRAC_W - 1);

    logic w_rdy_a, w_rdy_m, w_rdy_p, w_rdy_o;

    logic                    r_a_v;
    logic signed [ACC_W-1:0] r_a_acc;
    t_res_meta               r_a_meta;

    logic             r_m_v, r_m_neg;
    logic [MAG_W-1:0] r_m_mag;
    t_res_meta        r_m_meta;
    logic             w_neg;
    logic [MAG_W-1:0] w_mag;

    logic            r_p_v, r_p_neg;
    logic [PP_W-1:0] r_p_hi, r_p_lo;
    t_res_meta       r_p_meta;

    logic                  r_o_v, r_o_ovf;
    logic [DATA_WIDTH-1:0] r_o_value;
    t_res_meta             r_o_meta;

    logic [SUM_W-1:0]      w_sum;
    logic [RND_W-1:0]      w_rnd;
    logic                  w_ovf;
    logic [DATA_WIDTH-1:0] w_value;

    assign w_rdy_o = !r_o_v || i_ready;
    assign w_rdy_p = !r_p_v || w_rdy_o;
    assign w_rdy_m = !r_m_v || w_rdy_p;
    assign w_rdy_a = !r_a_v || w_rdy_m;
    assign o_ready = w_rdy_a;

    assign w_neg = r_a_acc[ACC_W-1];
    assign w_mag = MAG_W'(w_neg ? -r_a_acc : r_a_acc);

    assign w_sum = (SUM_W'(r_p_hi) << FRAC_W) + SUM_W'(r_p_lo) + HALF;
    assign w_rnd = w_sum[SUM_W-1:FRAC_W];
    assign w_ovf = w_rnd > (r_p_neg ? LIM_NEG : LIM_POS);

    always_comb begin
        if (w_ovf) begin
            w_value = r_p_neg ? VAL_MIN : VAL_MAX;
        end else if (r_p_neg) begin
            w_value = -DATA_WIDTH'(w_rnd);
        end else begin
            w_value = DATA_WIDTH'(w_rnd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_m_v <= 1'b0;
            r_p_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (w_rdy_a) begin
                r_a_v <= i_valid;
            end
            if (w_rdy_m) begin
                r_m_v <= r_a_v;
            end
            if (w_rdy_p) begin
                r_p_v <= r_m_v;
            end
            if (w_rdy_o) begin
                r_o_v <= r_p_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a && i_valid) begin
            r_a_acc  <= i_acc;
            r_a_meta <= i_meta;
        end
        if (w_rdy_m && r_a_v) begin
            r_m_mag  <= w_mag;
            r_m_neg  <= w_neg;
            r_m_meta <= r_a_meta;
        end
        if (w_rdy_p && r_m_v) begin
            r_p_hi   <= PP_W'(r_m_mag) * PP_W'(i_scale[SCALE_W-1:FRAC_W]);
            r_p_lo   <= PP_W'(r_m_mag) * PP_W'(i_scale[FRAC_W-1:0]);
            r_p_neg  <= r_m_neg;
            r_p_meta <= r_m_meta;
        end
        if (w_rdy_o && r_p_v) begin
            r_o_value <= w_value;
            r_o_ovf   <= w_ovf;
            r_o_meta  <= r_p_meta;
        end
    end

    assign o_valid    = r_o_v;
    assign o_value    = r_o_value;
    assign o_overflow = r_o_ovf;
    assign o_meta     = r_o_meta;

    a_clamp_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && r_o_ovf) |-> ((r_o_value == VAL_MIN) || (r_o_value == VAL_MAX)))
        else $error("overflow flagged on unclamped value");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && r_o_meta.done) |-> r_o_meta.last)
        else $error("final point not last of its run");

    a_product_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p_v && r_o_v && !i_ready) |=> (r_p_v && $stable(r_p_hi) && $stable(r_p_lo)))
        else $error("product stage lost while stalled");

endmodule

>>> rtl/five_point_laplacian_stencil_top.sv
// ----------------------------------------------------------------------------
// Five-point Laplacian stencil, top level
// Configuration registers, stencil window and scaling pipeline.
//
//   port group   dir   carries
//   s_axis_*     in    sample_value, boundary_value (raster order, column fastest)
//   m_axis_*     out   result_value, result_col, result_row, flags
//   i_cfg_*      in    register writes: 0 grid_size, 1 combined_scale
//
// Without stalls, one sample per cycle in rows that give at most one result each.
// The window issues one result a cycle when not stalled; in the last row every
// sample past the first gives two results, the final sample three; input waits.
// The first result of a request passes the window registers, then r_a, r_m,
// r_p and r_o to m_axis; further ones follow one per cycle unless m_axis stalls.
// Reset clears counters, valid flags and config; stored and data values persist.
// A stall on m_axis fills the pipeline, then drops s_axis_tready.
// ----------------------------------------------------------------------------
module five_point_laplacian_stencil_top
    import fpl_pkg::*;
#(
    parameter  int GRID_MAX   = 256,
    parameter  int DATA_WIDTH = 32,
    localparam int N_W        = $clog2(GRID_MAX + 1),
    localparam int ACC_W      = DATA_WIDTH + 4,
    localparam int IN_W       = ((2 * DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_W      = ((DATA_WIDTH + 2 * COORD_W + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_W-1:0]       s_axis_tdata,   // sample_value, boundary_value
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,   // result_value, result_col, result_row
    output logic [1:0]            m_axis_tuser,   // overflowed, last_of_run
    output logic                  m_axis_tlast    // frame_done
);

    localparam int CMP_W = (N_W > GRID_SIZE_W) ? N_W : GRID_SIZE_W;
    localparam logic [N_W-1:0]   GRID_N_RST = N_W'((GRID_MAX < GRID_RESET) ? GRID_MAX : GRID_RESET);
    localparam logic [CMP_W-1:0] GRID_MAX_C = CMP_W'(GRID_MAX);

    logic [N_W-1:0]     r_grid_n;
    logic [SCALE_W-1:0] r_scale;
    logic [CMP_W-1:0]   w_gs;
    logic [N_W-1:0]     w_gs_clamp;
    logic               w_restart;

    logic                    w_win_valid, w_win_ready;
    logic signed [ACC_W-1:0] w_win_acc;
    t_res_meta               w_win_meta;

    logic [DATA_WIDTH-1:0] w_value;
    logic                  w_ovf;
    t_res_meta             w_meta;

    assign w_gs = CMP_W'(i_cfg_data[GRID_SIZE_W-1:0]);

    always_comb begin
        if (w_gs < CMP_W'(2)) begin
            w_gs_clamp = N_W'(2);
        end else if (w_gs > GRID_MAX_C) begin
            w_gs_clamp = N_W'(GRID_MAX);
        end else begin
            w_gs_clamp = N_W'(w_gs);
        end
    end

    assign w_restart = i_cfg_we && (i_cfg_index == REG_GRID_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_n <= GRID_N_RST;
            r_scale  <= SCALE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_GRID_SIZE: begin
                    r_grid_n <= w_gs_clamp;
                end
                REG_COMBINED_SCALE: begin
                    r_scale <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    fpl_window #(.GRID_MAX(GRID_MAX), .DATA_WIDTH(DATA_WIDTH)) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_grid_n   (r_grid_n),
        .i_restart  (w_restart),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_sample   (s_axis_tdata[DATA_WIDTH-1:0]),
        .i_boundary (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
        .o_valid    (w_win_valid),
        .i_ready    (w_win_ready),
        .o_acc      (w_win_acc),
        .o_meta     (w_win_meta)
    );

    fpl_scale #(.DATA_WIDTH(DATA_WIDTH)) u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_scale    (r_scale),
        .i_valid    (w_win_valid),
        .o_ready    (w_win_ready),
        .i_acc      (w_win_acc),
        .i_meta     (w_win_meta),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_value    (w_value),
        .o_overflow (w_ovf),
        .o_meta     (w_meta)
    );

    assign m_axis_tdata = OUT_W'({w_meta.row, w_meta.col, w_value});
    assign m_axis_tuser = {w_meta.last, w_ovf};
    assign m_axis_tlast = w_meta.done;

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// Five-point Laplacian stencil: self-checking testbench
// Streams grid samples with boundary terms through the stencil under a range
// of grid sizes and scale factors. A predictor inside the bench works out
// every scaled Laplacian on request acceptance. The monitor compares each
// result, field by field, against the oldest predicted one. Both stream sides
// stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import fpl_pkg::*;

    localparam int GRID_LIMIT   = 256;
    localparam int SETTLE_WAIT  = 12;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 60;

    typedef struct packed {
        logic [31:0]        value;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               ovf;
        logic               last;
        logic               done;
    } t_lap_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [63:0]           s_axis_tdata = '0;   // sample_value, boundary_value
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [47:0]           m_axis_tdata;        // result_value, result_col, result_row
    logic [1:0]            m_axis_tuser;        // overflowed, last_of_run
    logic                  m_axis_tlast;        // frame_done

    five_point_laplacian_stencil_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    logic [63:0]   pending_samples [$];
    t_lap_result   expected_laplacians [$];

    // predictor state
    logic [GRID_SIZE_W-1:0] grid_reg = GRID_SIZE_W'(GRID_RESET);
    logic [SCALE_W-1:0]     scale_reg = SCALE_RESET;
    longint                 upper_row [GRID_LIMIT];
    longint                 centre_row [GRID_LIMIT];
    longint                 centre_bnd [GRID_LIMIT];
    int unsigned            col_cnt = 0;
    int unsigned            row_cnt = 0;
    longint                 diag_left = 0;
    longint                 prev_sample = 0;
    longint                 prev_bnd = 0;

    bit          steady = 1'b0;
    int unsigned mismatch_count = 0;
    int unsigned samples_sent = 0;
    int unsigned results_checked = 0;
    int unsigned saturated_seen = 0;
    int unsigned frames_seen = 0;
    int unsigned settings_used = 0;
    int unsigned cycle_count = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic bit take_gap();
        return !steady && ($urandom_range(99) < 16);
    endfunction

    function automatic int unsigned grid_points();
        if (grid_reg < 2) return 2;
        if (grid_reg > GRID_LIMIT) return GRID_LIMIT;
        return grid_reg;
    endfunction

    function automatic t_lap_result scale_point(longint acc, int unsigned col,
                                                int unsigned row, bit done);
        t_lap_result res;
        bit neg;
        longint unsigned m;
        logic [127:0] prod;
        logic [127:0] limit;
        neg = acc < 0;
        m = neg ? longint'(-acc) : acc;
        prod = ({64'd0, m} * {96'd0, scale_reg} + 128'h8000) >> FRAC_W;
        limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        res.ovf = prod > limit;
        if (res.ovf) prod = limit;
        res.value = neg ? -prod[31:0] : prod[31:0];
        res.col = col[COORD_W-1:0];
        res.row = row[COORD_W-1:0];
        res.last = 1'b0;
        res.done = done;
        return res;
    endfunction

    task automatic step_stencil(input logic [31:0] smp, input logic [31:0] bnd);
        int unsigned n, c, r;
        longint x, b, old_c, old_b, acc;
        t_lap_result res [3];
        int cnt;
        n = grid_points();
        c = col_cnt;
        r = row_cnt;
        cnt = 0;
        x = longint'($signed(smp));
        b = longint'($signed(bnd));
        if (c >= n || r >= n) begin
            c = 0;
            r = 0;
        end
        old_c = centre_row[c];
        old_b = centre_bnd[c];
        if (r > 0) begin
            acc = -4 * old_c + old_b + x;
            if (c > 0) acc += diag_left;
            if (c + 1 < n) acc += centre_row[c + 1];
            if (r > 1) acc += upper_row[c];
            res[cnt] = scale_point(acc, c, r - 1, 1'b0);
            cnt++;
        end
        upper_row[c] = old_c;
        centre_row[c] = x;
        centre_bnd[c] = b;
        diag_left = old_c;
        if (r == n - 1) begin
            if (c > 0) begin
                acc = -4 * prev_sample + prev_bnd + x + upper_row[c - 1];
                if (c > 1) acc += centre_row[c - 2];
                res[cnt] = scale_point(acc, c - 1, r, 1'b0);
                cnt++;
            end
            if (c == n - 1) begin
                acc = -4 * x + b + prev_sample + upper_row[c];
                res[cnt] = scale_point(acc, c, r, 1'b1);
                cnt++;
            end
        end
        prev_sample = x;
        prev_bnd = b;
        c++;
        if (c >= n) begin
            c = 0;
            r++;
            if (r >= n) r = 0;
        end
        col_cnt = c;
        row_cnt = r;
        for (int k = 0; k < cnt; k++) begin
            if (k == cnt - 1) res[k].last = 1'b1;
            expected_laplacians.push_back(res[k]);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                step_stencil(s_axis_tdata[31:0], s_axis_tdata[63:32]);
                samples_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_samples.size() != 0 && !take_gap()) begin
                    s_axis_tdata <= pending_samples.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : monitor
        t_lap_result got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.value = m_axis_tdata[31:0];
                got.col = m_axis_tdata[39:32];
                got.row = m_axis_tdata[47:40];
                got.ovf = m_axis_tuser[0];
                got.last = m_axis_tuser[1];
                got.done = m_axis_tlast;
                if (expected_laplacians.size() == 0) begin
                    $display("%0t: unexpected result expected none got %h", $time, got);
                    mismatch_count++;
                end else begin
                    want = expected_laplacians.pop_front();
                    check_field("result_value", want.value, got.value);
                    check_field("result_col", 32'(want.col), 32'(got.col));
                    check_field("result_row", 32'(want.row), 32'(got.row));
                    check_field("overflowed", 32'(want.ovf), 32'(got.ovf));
                    check_field("last_of_run", 32'(want.last), 32'(got.last));
                    check_field("frame_done", 32'(want.done), 32'(got.done));
                    results_checked++;
                    if (want.ovf) saturated_seen++;
                    if (want.done) frames_seen++;
                end
            end
            m_axis_tready <= !take_gap();
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run timed out with %0d results outstanding", $time,
                     expected_laplacians.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pending_samples.size() != 0 || s_axis_tvalid ||
               expected_laplacians.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_GRID_SIZE) begin
            grid_reg = data[GRID_SIZE_W-1:0];
            col_cnt = 0;
            row_cnt = 0;
        end else if (idx == REG_COMBINED_SCALE) begin
            scale_reg = data;
        end
        settings_used++;
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] grid,
                             input logic [CFG_DATA_W-1:0] scale);
        wait_idle();
        write_reg(REG_GRID_SIZE, grid);
        write_reg(REG_COMBINED_SCALE, scale);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3, 4: return $urandom();
            default: return $urandom_range(2097152) - 32'd1048576;
        endcase
    endfunction

    function automatic logic [31:0] pick_scale();
        case ($urandom_range(5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return SCALE_RESET;
            3: return $urandom();
            default: return $urandom_range(1 << 20);
        endcase
    endfunction

    task automatic queue_samples(input int unsigned count);
        repeat (count) pending_samples.push_back({pick_value(), pick_value()});
    endtask

    initial begin
        int unsigned random_sent;
        int unsigned n;
        random_sent = 0;
        foreach (upper_row[k]) begin
            upper_row[k] = 0;
            centre_row[k] = 0;
            centre_bnd[k] = 0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // smallest grid, unit scale, field extremes
        configure(2, SCALE_RESET);
        pending_samples.push_back({32'h7FFF_FFFF, 32'h7FFF_FFFF});
        pending_samples.push_back({32'h8000_0000, 32'h8000_0000});
        pending_samples.push_back({32'hFFFF_FFFF, 32'h0000_0000});
        pending_samples.push_back({32'h0000_0000, 32'hFFFF_FFFF});
        // largest scale saturates both ways
        configure(2, 32'hFFFF_FFFF);
        pending_samples.push_back({32'h0000_0001, 32'h8000_0000});
        pending_samples.push_back({32'h7FFF_FFFF, 32'h0000_0000});
        pending_samples.push_back({32'hFFFF_FFFF, 32'h8000_0000});
        pending_samples.push_back({32'h0000_0000, 32'h7FFF_FFFF});
        // grid below range acts as two, zero scale
        configure(1, 32'h0);
        queue_samples(4);
        // half scale on odd sums: rounding ties
        configure(3, 32'h0000_8000);
        repeat (9) pending_samples.push_back({32'($urandom_range(7)) - 32'd3,
                                              32'($urandom_range(7)) - 32'd3});

        while (random_sent < RANDOM_ITEMS) begin
            wait_idle();
            case ($urandom_range(7))
                0: write_reg(REG_GRID_SIZE, 0);
                1: write_reg(REG_GRID_SIZE, 1);
                default: write_reg(REG_GRID_SIZE, $urandom_range(2, 7));
            endcase
            write_reg(REG_COMBINED_SCALE, pick_scale());
            n = grid_points();
            n = $urandom_range(1, 2) * n * n +
                (($urandom_range(3) == 0) ? $urandom_range(n * n - 1) : 0);
            queue_samples(n);
            random_sent += n;
        end

        // clamped large grid: one full row and the start of the next,
        // the first part streamed with no idling on either side
        wait_idle();
        case ($urandom_range(2))
            0: write_reg(REG_GRID_SIZE, GRID_LIMIT);
            1: write_reg(REG_GRID_SIZE, 300);
            default: write_reg(REG_GRID_SIZE, 511);
        endcase
        write_reg(REG_COMBINED_SCALE, pick_scale());
        steady = 1'b1;
        queue_samples(GRID_LIMIT + $urandom_range(1, 24));
        while (pending_samples.size() > 180) @(negedge i_clk);
        steady = 1'b0;

        wait_idle();
        $display("Streamed %0d samples under %0d register writes; checked %0d results",
                 samples_sent, settings_used, results_checked);
        $display("including %0d saturated results and %0d completed frames",
                 saturated_seen, frames_seen);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> five_point_laplacian_stencil_top.f
rtl/fpl_pkg.sv
rtl/fpl_line_store.sv
rtl/fpl_window.sv
rtl/fpl_scale.sv
rtl/five_point_laplacian_stencil_top.sv
test/tb_top.sv
